[src/trapezoid_bin_resampler_defines.svh]
// Assertion macros shared by the resampler checker.
`ifndef TRAPEZOID_BIN_RESAMPLER_DEFINES_SVH
`define TRAPEZOID_BIN_RESAMPLER_DEFINES_SVH

// same-cycle implication under the async reset
`define TBR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the async reset
`define TBR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/tbr_pkg.sv]
// Shared types, widths and codes of the trapezoid bin resampler.
`default_nettype none
package tbr_pkg;

	localparam int POS_W      = 32;
	localparam int SPC_W      = 31;
	localparam int RCP_W      = 32;
	localparam int BU_W       = 17;
	localparam int SAMP_W     = 24;
	localparam int SUM_W      = 25;
	localparam int ACC_W      = 48;
	localparam int IDX_W      = 16;
	localparam int RES_W      = 65;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 25;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [POS_W-1:0] SAMPLE_ORIGIN_RST = 32'h0000_0000;
	localparam logic [SPC_W-1:0] SAMPLE_SPACING_RST = 31'h0001_0000;
	localparam logic [POS_W-1:0] BIN_ORIGIN_RST = 32'h0000_0000;
	localparam logic [SPC_W-1:0] BIN_SPACING_RST = 31'h0001_0000;
	localparam logic [RCP_W-1:0] BIN_RECIP_RST = 32'h0001_0000;
	localparam logic [BU_W-1:0] BINS_USED_RST = 17'd1;
	localparam logic [BU_W-1:0] BINS_MAX = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_ORIGIN  = 3'd0,
		REG_SAMPLE_SPACING = 3'd1,
		REG_BIN_ORIGIN     = 3'd2,
		REG_BIN_SPACING    = 3'd3,
		REG_BIN_RECIP      = 3'd4,
		REG_BINS_USED      = 3'd5
	} reg_idx_t;

	typedef enum logic [11:0] {
		ST_IDLE    = 12'b0000_0000_0001,
		ST_WIN     = 12'b0000_0000_0010,
		ST_WIDTH   = 12'b0000_0000_0100,
		ST_MUL     = 12'b0000_0000_1000,
		ST_ACC     = 12'b0000_0001_0000,
		ST_MAG     = 12'b0000_0010_0000,
		ST_EMUL_LO = 12'b0000_0100_0000,
		ST_EMUL_HI = 12'b0000_1000_0000,
		ST_ESUM    = 12'b0001_0000_0000,
		ST_EOUT    = 12'b0010_0000_0000,
		ST_CLOSE   = 12'b0100_0000_0000,
		ST_COMMIT  = 12'b1000_0000_0000
	} state_t;

	typedef struct packed {
		logic signed [SAMP_W-1:0] sample_value;
		logic                     final_sample;
	} in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] bin_value;
		logic [IDX_W-1:0]        bin_number;
		logic                    final_bin;
	} out_t;

endpackage
`default_nettype wire

[src/tbr_mul.sv]
// Shared unsigned multiplier with registered product.
`default_nettype none
module tbr_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tbr_pkg::MUL_A_W-1:0] a,
	input  logic [tbr_pkg::MUL_B_W-1:0] b,
	output logic [tbr_pkg::MUL_P_W-1:0] prod
);

	logic [tbr_pkg::MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= tbr_pkg::MUL_P_W'(a) * tbr_pkg::MUL_P_W'(b);
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

[src/trapezoid_bin_resampler.sv]
// Top level: trapezoid-rule rebinning of a sample stream into uniform bins.
// Samples are taken only in the idle state; sample_stall is high while the sequencer works.
// A bin close adds the output steps, and a stream's first sample only primes the window.
// A final sample flushes the open bin unless all bins are done; result_stall can hold it.
// All products come from one shared 32x25 multiplier stepped by the sequencer.
// Reset loads register defaults and idles the sequencer with no stream open.
`default_nettype none
module trapezoid_bin_resampler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [tbr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  tbr_pkg::in_t                   sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output tbr_pkg::out_t                  result
);

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// configuration
	logic signed [31:0]                sorg_q;
	logic [tbr_pkg::SPC_W-1:0]         sspc_q;
	logic signed [31:0]                borg_q;
	logic [tbr_pkg::SPC_W-1:0]         bspc_q;
	logic [tbr_pkg::RCP_W-1:0]         rcp_q;
	logic [tbr_pkg::BU_W-1:0]          bu_q;

	// stream state
	tbr_pkg::state_t                   state_q;
	logic                              have_q;
	logic                              done_q;
	logic signed [tbr_pkg::SAMP_W-1:0] prev_q;
	logic signed [31:0]                istart_q;
	logic signed [31:0]                upper_q;
	logic [tbr_pkg::ACC_W-1:0]         acc_q;
	logic [tbr_pkg::IDX_W-1:0]         idx_q;

	// working registers
	logic                              fin_q;
	logic                              final_q;
	logic signed [31:0]                b_q;
	logic                              sneg_q;
	logic [tbr_pkg::SUM_W-1:0]         smag_q;
	logic signed [32:0]                lo_q;
	logic signed [31:0]                hi_q;
	logic signed [32:0]                start_q;
	logic signed [31:0]                end_q;
	logic                              cross_q;
	logic                              second_q;
	logic [tbr_pkg::SPC_W-1:0]         w_q;
	logic                              mneg_q;
	logic [tbr_pkg::ACC_W-1:0]         mag_q;
	logic [tbr_pkg::RES_W-1:0]         res_q;
	logic                              out_valid_q;
	tbr_pkg::out_t                     out_q;

	// multiplier
	logic                              mul_en;
	logic [tbr_pkg::MUL_A_W-1:0]       mul_a;
	logic [tbr_pkg::MUL_B_W-1:0]       mul_b;
	logic [tbr_pkg::MUL_P_W-1:0]       prod;

	// combinational
	logic signed [33:0]                b_sum;
	logic signed [33:0]                up_init_sum;
	logic signed [33:0]                up_next_sum;
	logic signed [31:0]                upper_nx;
	logic signed [32:0]                lo_nx;
	logic signed [32:0]                istart33;
	logic signed [32:0]                span_start;
	logic signed [31:0]                span_end;
	logic signed [33:0]                width_diff;
	logic [tbr_pkg::SPC_W-1:0]         w_nx;
	logic signed [tbr_pkg::SUM_W-1:0]  sum_s;
	logic [tbr_pkg::SUM_W-1:0]         sum_u;
	logic [tbr_pkg::SUM_W-1:0]         smag_nx;
	logic [49:0]                       span_p;
	logic [49:0]                       acc_ext;
	logic [49:0]                       acc_sum;
	logic [tbr_pkg::ACC_W-1:0]         acc_nx;
	logic [tbr_pkg::ACC_W-1:0]         mag_nx;
	logic [tbr_pkg::BU_W-1:0]          bins_eff;
	logic [tbr_pkg::BU_W-1:0]          idx_inc;
	logic                              close_last;
	logic                              big_pos;
	logic                              big_neg;
	logic [31:0]                       mag32;
	logic [31:0]                       val32;
	logic                              out_free;

	tbr_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign b_sum       = $signed({{2{istart_q[31]}}, istart_q}) + $signed({3'b000, sspc_q});
	assign up_init_sum = $signed({{2{borg_q[31]}}, borg_q}) + $signed({4'b0000, bspc_q[30:1]});
	assign up_next_sum = $signed({{2{upper_q[31]}}, upper_q}) + $signed({3'b000, bspc_q});
	assign upper_nx    = sat32(up_next_sum);
	assign lo_nx       = $signed({upper_q[31], upper_q}) - $signed({2'b00, bspc_q});
	assign istart33    = $signed({istart_q[31], istart_q});
	assign span_start  = (istart33 > lo_q) ? istart33 : lo_q;
	assign span_end    = (b_q < hi_q) ? b_q : hi_q;
	assign width_diff  = $signed({{2{end_q[31]}}, end_q}) - $signed({start_q[32], start_q});
	assign w_nx        = (width_diff > 34'sd0) ? width_diff[30:0] : '0;

	assign sum_s   = $signed({prev_q[23], prev_q})
		+ $signed({sample.sample_value[23], sample.sample_value});
	assign sum_u   = sum_s;
	assign smag_nx = sum_u[24] ? (25'd0 - sum_u) : sum_u;

	assign span_p  = {10'd0, prod[56:17]};
	assign acc_ext = {{2{acc_q[47]}}, acc_q};
	assign acc_sum = sneg_q ? (acc_ext - span_p) : (acc_ext + span_p);

	always_comb begin
		if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111) begin
			acc_nx = acc_sum[47:0];
		end else if (acc_sum[49]) begin
			acc_nx = 48'h8000_0000_0000;
		end else begin
			acc_nx = 48'h7FFF_FFFF_FFFF;
		end
	end

	assign mag_nx = acc_q[47] ? (48'd0 - acc_q) : acc_q;

	always_comb begin
		if (bu_q == '0) begin
			bins_eff = 17'd1;
		end else if (bu_q > tbr_pkg::BINS_MAX) begin
			bins_eff = tbr_pkg::BINS_MAX;
		end else begin
			bins_eff = bu_q;
		end
	end

	assign idx_inc    = {1'b0, idx_q} + 17'd1;
	assign close_last = (idx_inc >= bins_eff);

	assign big_pos = |res_q[64:31];
	assign big_neg = (|res_q[64:32]) || (res_q[31] && (|res_q[30:0]));

	always_comb begin
		if (mneg_q) begin
			mag32 = big_neg ? 32'h8000_0000 : res_q[31:0];
			val32 = 32'd0 - mag32;
		end else begin
			mag32 = res_q[31:0];
			val32 = big_pos ? 32'h7FFF_FFFF : res_q[31:0];
		end
	end

	always_comb begin
		mul_en = (state_q == tbr_pkg::ST_MUL) || (state_q == tbr_pkg::ST_EMUL_LO)
			|| (state_q == tbr_pkg::ST_EMUL_HI);
		mul_a  = rcp_q;
		mul_b  = {1'b0, mag_q[23:0]};
		if (state_q == tbr_pkg::ST_MUL) begin
			mul_a = {1'b0, w_q};
			mul_b = smag_q;
		end else if (state_q == tbr_pkg::ST_EMUL_HI) begin
			mul_b = {1'b0, mag_q[47:24]};
		end
	end

	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorg_q <= tbr_pkg::SAMPLE_ORIGIN_RST;
			sspc_q <= tbr_pkg::SAMPLE_SPACING_RST;
			borg_q <= tbr_pkg::BIN_ORIGIN_RST;
			bspc_q <= tbr_pkg::BIN_SPACING_RST;
			rcp_q  <= tbr_pkg::BIN_RECIP_RST;
			bu_q   <= tbr_pkg::BINS_USED_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				tbr_pkg::REG_SAMPLE_ORIGIN:  sorg_q <= cfg_data;
				tbr_pkg::REG_SAMPLE_SPACING: sspc_q <= cfg_data[30:0];
				tbr_pkg::REG_BIN_ORIGIN:     borg_q <= cfg_data;
				tbr_pkg::REG_BIN_SPACING:    bspc_q <= cfg_data[30:0];
				tbr_pkg::REG_BIN_RECIP:      rcp_q  <= cfg_data;
				tbr_pkg::REG_BINS_USED:      bu_q   <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbr_pkg::ST_IDLE;
			have_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall && state_q != tbr_pkg::ST_EOUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tbr_pkg::ST_IDLE: if (sample_valid) begin
					if (!have_q) begin
						have_q  <= 1'b1;
						done_q  <= 1'b0;
						state_q <= sample.final_sample ? tbr_pkg::ST_MAG : tbr_pkg::ST_IDLE;
					end else begin
						state_q <= done_q ? tbr_pkg::ST_COMMIT : tbr_pkg::ST_WIN;
					end
				end
				tbr_pkg::ST_WIN:     state_q <= tbr_pkg::ST_WIDTH;
				tbr_pkg::ST_WIDTH:   state_q <= tbr_pkg::ST_MUL;
				tbr_pkg::ST_MUL:     state_q <= tbr_pkg::ST_ACC;
				tbr_pkg::ST_ACC: begin
					if (second_q || !cross_q) begin
						state_q <= tbr_pkg::ST_COMMIT;
					end else begin
						state_q <= tbr_pkg::ST_MAG;
					end
				end
				tbr_pkg::ST_MAG:     state_q <= tbr_pkg::ST_EMUL_LO;
				tbr_pkg::ST_EMUL_LO: state_q <= tbr_pkg::ST_EMUL_HI;
				tbr_pkg::ST_EMUL_HI: state_q <= tbr_pkg::ST_ESUM;
				tbr_pkg::ST_ESUM:    state_q <= tbr_pkg::ST_EOUT;
				tbr_pkg::ST_EOUT: if (out_free) begin
					out_valid_q <= 1'b1;
					if (final_q) begin
						have_q  <= 1'b0;
						done_q  <= 1'b0;
						state_q <= tbr_pkg::ST_IDLE;
					end else begin
						state_q <= tbr_pkg::ST_CLOSE;
					end
				end
				tbr_pkg::ST_CLOSE: begin
					if (close_last) begin
						done_q  <= 1'b1;
						state_q <= tbr_pkg::ST_COMMIT;
					end else begin
						state_q <= tbr_pkg::ST_WIN;
					end
				end
				tbr_pkg::ST_COMMIT: begin
					if (fin_q && !done_q) begin
						state_q <= tbr_pkg::ST_MAG;
					end else begin
						if (fin_q) begin
							have_q <= 1'b0;
							done_q <= 1'b0;
						end
						state_q <= tbr_pkg::ST_IDLE;
					end
				end
				default: state_q <= tbr_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tbr_pkg::ST_IDLE: if (sample_valid) begin
				fin_q  <= sample.final_sample;
				prev_q <= sample.sample_value;
				sneg_q <= sum_s[24];
				smag_q <= smag_nx;
				if (!have_q) begin
					istart_q <= sorg_q;
					upper_q  <= sat32(up_init_sum);
					acc_q    <= '0;
					idx_q    <= '0;
					final_q  <= 1'b1;
				end else begin
					b_q      <= sat32(b_sum);
					lo_q     <= lo_nx;
					hi_q     <= upper_q;
					second_q <= 1'b0;
				end
			end
			tbr_pkg::ST_WIN: begin
				start_q <= span_start;
				end_q   <= span_end;
				if (!second_q) begin
					cross_q <= (b_q > upper_q);
				end
			end
			tbr_pkg::ST_WIDTH: w_q <= w_nx;
			tbr_pkg::ST_MUL: begin
			end
			tbr_pkg::ST_ACC: begin
				acc_q   <= acc_nx;
				final_q <= 1'b0;
			end
			tbr_pkg::ST_MAG: begin
				mneg_q <= acc_q[47];
				mag_q  <= mag_nx;
			end
			tbr_pkg::ST_EMUL_LO: begin
			end
			tbr_pkg::ST_EMUL_HI: res_q <= {24'd0, prod[56:16]};
			tbr_pkg::ST_ESUM:    res_q <= res_q + {prod, 8'd0};
			tbr_pkg::ST_EOUT: if (out_free) begin
				out_q.bin_value  <= val32;
				out_q.bin_number <= idx_q;
				out_q.final_bin  <= final_q || close_last;
			end
			tbr_pkg::ST_CLOSE: if (!close_last) begin
				idx_q    <= idx_q + 16'd1;
				acc_q    <= '0;
				upper_q  <= upper_nx;
				lo_q     <= $signed({upper_q[31], upper_q});
				hi_q     <= upper_nx;
				second_q <= 1'b1;
			end
			tbr_pkg::ST_COMMIT: begin
				istart_q <= b_q;
				final_q  <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign sample_stall = (state_q != tbr_pkg::ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

[src/tbr_checker.sv]
// Port-level checker for the resampler and its bind to the top level.
`default_nettype none
`include "trapezoid_bin_resampler_defines.svh"
module tbr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          sample_valid,
	input logic          sample_stall,
	input logic          result_valid,
	input logic          result_stall,
	input tbr_pkg::out_t result
);

	logic [tbr_pkg::IDX_W-1:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
		end else if (result_valid && !result_stall) begin
			exp_q <= result.final_bin ? '0 : (result.bin_number + 16'd1);
		end
	end

	`TBR_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
	`TBR_ASSERT_NXT(a_quiet_after_request, clk, arst_n, sample_valid && !sample_stall, !$rose(result_valid), "result raised right after a request")
	`TBR_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(result_valid), $past(sample_stall), "result raised while sequencer idle")
	`TBR_ASSERT_IMP(a_bin_order, clk, arst_n, result_valid, result.bin_number == exp_q, "bin numbers out of order")

endmodule

bind trapezoid_bin_resampler tbr_checker u_tbr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire
